[hw/rtl/assert_macros.svh]
// Assertion macros shared by the contour cell modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[hw/rtl/msq_pkg.sv]
// Shared types and constants of the contour cell unit.
package msq_pkg;
	localparam int SampleBits = 16;
	localparam int FracBits = 12;
	localparam int MaxWidth = 256;
	localparam int QDepth = 2;

	typedef enum logic [1:0] {
		REG_THRESHOLD = 2'd0,
		REG_WIDTH = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV_A,
		BK_DIV_B,
		BK_OUT
	} bk_state_t;

	// One classified cell handed from front to back.
	typedef struct packed {
		logic [7:0] row;
		logic [7:0] col;
		logic [3:0] code;
		logic [1:0] ea;
		logic [1:0] eb;
		logic signed [SampleBits:0] num_a;
		logic signed [SampleBits:0] den_a;
		logic signed [SampleBits:0] num_b;
		logic signed [SampleBits:0] den_b;
		logic last;
	} cell_t;
endpackage

[hw/rtl/msq_front.sv]
// Front end: line store, cell assembly, case code and edge selection.
module msq_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [msq_pkg::SampleBits-1:0] sample,
	input  logic signed [msq_pkg::SampleBits-1:0] thr,
	input  logic [8:0] gw,
	input  logic [8:0] gh,
	output logic cell_valid,
	output msq_pkg::cell_t cword,
	input  logic q_full
);
	import msq_pkg::*;

	logic signed [SampleBits-1:0] row_mem [MaxWidth];
	logic signed [SampleBits-1:0] up_s1, samp_s1, left_q, upleft_q;
	logic [7:0] col_q, row_q, col_s1, row_s1;
	logic v_s1, last_s1;
	logic [8:0] w_eff, h_eff, col_nx, row_nx;

	assign w_eff = (gw < 9'd2) ? 9'd2 : ((gw > 9'(MaxWidth)) ? 9'(MaxWidth) : gw);
	assign h_eff = (gh < 9'd2) ? 9'd2 : ((gh > 9'd256) ? 9'd256 : gh);

	// Stall while the stage holds a word the queue cannot take.
	assign in_stall = v_s1 && q_full;
	logic acc;
	assign acc = in_valid && !in_stall;

	// Advance raster counters.
	always_comb begin
		col_nx = {1'b0, col_q} + 9'd1;
		row_nx = {1'b0, row_q};
		if (col_nx >= w_eff) begin
			col_nx = 9'd0;
			row_nx = row_nx + 9'd1;
		end
		if (row_nx >= h_eff) row_nx = 9'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			if (acc) begin
				col_q <= col_nx[7:0];
				row_q <= row_nx[7:0];
			end
			if (acc) v_s1 <= 1'b1;
			else if (!q_full) v_s1 <= 1'b0;
		end
	end

	// Read the line store and capture the position.
	always_ff @(posedge clk) begin
		if (acc) begin
			up_s1 <= row_mem[col_q];
			row_mem[col_q] <= sample;
			samp_s1 <= sample;
			col_s1 <= col_q;
			row_s1 <= row_q;
			last_s1 <= ({1'b0, row_q} == h_eff - 9'd1) && ({1'b0, col_q} == w_eff - 9'd1);
		end
	end

	// Hold the neighbors; they move as each stage-one word leaves.
	logic leave;
	assign leave = v_s1 && !q_full;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			upleft_q <= '0;
		end else if (leave) begin
			left_q <= samp_s1;
			upleft_q <= up_s1;
		end
	end

	// Classify the cell.
	logic signed [SampleBits-1:0] k [4];
	logic [3:0] code;
	logic signed [SampleBits+1:0] sum, t4;
	logic [1:0] ea, eb;
	always_comb begin
		k[0] = upleft_q;
		k[1] = up_s1;
		k[2] = samp_s1;
		k[3] = left_q;
		code = {k[3] < thr, k[2] < thr, k[1] < thr, k[0] < thr};
		sum = (SampleBits+2)'(k[0]) + (SampleBits+2)'(k[1]) + (SampleBits+2)'(k[2])
			+ (SampleBits+2)'(k[3]);
		t4 = (SampleBits+2)'(thr) <<< 2;
		ea = 2'd0;
		eb = 2'd0;
		case (code)
			4'd1, 4'd14: begin ea = 2'd0; eb = 2'd3; end
			4'd2, 4'd13: begin ea = 2'd0; eb = 2'd1; end
			4'd4, 4'd11: begin ea = 2'd1; eb = 2'd2; end
			4'd7, 4'd8: begin ea = 2'd2; eb = 2'd3; end
			4'd3, 4'd12: begin ea = 2'd3; eb = 2'd1; end
			4'd6, 4'd9: begin ea = 2'd0; eb = 2'd2; end
			4'd5: begin
				if (sum > t4) begin ea = 2'd0; eb = 2'd3; end
				else begin ea = 2'd1; eb = 2'd2; end
			end
			4'd10: begin
				if (sum <= t4) begin ea = 2'd0; eb = 2'd3; end
				else begin ea = 2'd1; eb = 2'd2; end
			end
			default: ;
		endcase
		cword.row = row_s1 - 8'd1;
		cword.col = col_s1 - 8'd1;
		cword.code = code;
		cword.ea = ea;
		cword.eb = eb;
		cword.num_a = (SampleBits+1)'(thr) - (SampleBits+1)'(k[ea]);
		cword.den_a = (SampleBits+1)'(k[ea + 2'd1]) - (SampleBits+1)'(k[ea]);
		cword.num_b = (SampleBits+1)'(thr) - (SampleBits+1)'(k[eb]);
		cword.den_b = (SampleBits+1)'(k[eb + 2'd1]) - (SampleBits+1)'(k[eb]);
		cword.last = last_s1;
	end

	assign cell_valid = leave && row_s1 != 8'd0 && col_s1 != 8'd0
		&& code != 4'd0 && code != 4'd15;
endmodule

[hw/rtl/msq_queue.sv]
// Two-entry queue between classifier and divider.
module msq_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  msq_pkg::cell_t din,
	output logic full,
	output logic pop_valid,
	input  logic pop,
	output msq_pkg::cell_t dout
);
	import msq_pkg::*;

	cell_t mem_q [QDepth];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'(QDepth);
	assign pop_valid = cnt_q != 2'd0;
	assign dout = mem_q[rp_q];

	// Write at the tail, read from the head.
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	`include "assert_macros.svh"
	`ASSERT_IMPL(a_no_overflow, clk, arst_n, full, !push || pop, "queue overflow")
	`ASSERT_IMPL(a_no_underflow, clk, arst_n, pop, pop_valid, "queue underflow")
	`ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= 2'(QDepth), "queue count")
endmodule

[hw/rtl/msq_back.sv]
// Back end: shared restoring divider for both crossings and output register.
module msq_back (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	output logic q_pop,
	input  msq_pkg::cell_t cword,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] cell_row,
	output logic [7:0] cell_col,
	output logic [3:0] case_code,
	output logic [1:0] edge_a,
	output logic [12:0] frac_a,
	output logic [1:0] edge_b,
	output logic [12:0] frac_b,
	output logic last_cell
);
	import msq_pkg::*;

	localparam int QW = SampleBits + FracBits + 1;
	localparam int ONE = 1 << FracBits;

	bk_state_t st_q, st_nx;
	cell_t c_q;
	logic [QW-1:0] rem_q, quo_q;
	logic [SampleBits:0] d_q;
	logic [4:0] step_q;
	logic zero_q;

	// Absolute value of a signed numerator or denominator.
	function automatic logic [SampleBits:0] absv(input logic signed [SampleBits:0] v);
		return v[SampleBits] ? (SampleBits+1)'(0) - v : v;
	endfunction

	logic signed [SampleBits:0] n_sel, d_sel;
	assign n_sel = (st_q == BK_IDLE) ? cword.num_a : c_q.num_b;
	assign d_sel = (st_q == BK_IDLE) ? cword.den_a : c_q.den_b;

	logic start;
	logic [QW:0] trial;
	logic [QW-1:0] q_shift;
	assign start = (st_q == BK_IDLE && q_valid) || (st_q == BK_DIV_A && step_q == 5'd0);
	assign q_pop = st_q == BK_IDLE && q_valid;
	assign trial = {rem_q, quo_q[QW-1]} - {(QW-SampleBits)'(0), d_q};
	assign q_shift = {quo_q[QW-2:0], !trial[QW]};

	// Next state.
	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			BK_IDLE: if (q_valid) st_nx = BK_DIV_A;
			BK_DIV_A: if (step_q == 5'd0) st_nx = BK_DIV_B;
			BK_DIV_B: if (step_q == 5'd0) st_nx = BK_OUT;
			BK_OUT: if (!out_stall) st_nx = BK_IDLE;
			default: st_nx = BK_IDLE;
		endcase
	end

	// Output decode.
	always_comb begin
		out_valid = st_q == BK_OUT;
	end

	logic [12:0] res;
	assign res = (zero_q || quo_q > QW'(ONE)) ? (zero_q ? 13'd0 : 13'(ONE)) : 13'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			step_q <= '0;
		end else begin
			st_q <= st_nx;
			if (start) step_q <= 5'(QW);
			else if (step_q != 5'd0) step_q <= step_q - 5'd1;
		end
	end

	// Run one quotient bit a cycle; load a new division on start.
	always_ff @(posedge clk) begin
		if (q_pop) c_q <= cword;
		if (start) begin
			rem_q <= '0;
			quo_q <= QW'(absv(n_sel)) << FracBits;
			d_q <= absv(d_sel);
			zero_q <= d_sel == '0 || n_sel == '0 || (n_sel[SampleBits] != d_sel[SampleBits]);
		end else begin
			rem_q <= trial[QW] ? {rem_q[QW-2:0], quo_q[QW-1]} : trial[QW-1:0];
			quo_q <= q_shift;
		end
		if (st_q == BK_DIV_A && step_q == 5'd0) frac_a <= res;
		if (st_q == BK_DIV_B && step_q == 5'd0) frac_b <= res;
	end

	assign cell_row = c_q.row;
	assign cell_col = c_q.col;
	assign case_code = c_q.code;
	assign edge_a = c_q.ea;
	assign edge_b = c_q.eb;
	assign last_cell = c_q.last;

	`include "assert_macros.svh"
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(frac_a),
		"result dropped while stalled")
	`ASSERT_IMPL(a_pop_idle, clk, arst_n, q_pop, st_q == BK_IDLE, "pop while busy")
endmodule

[hw/rtl/marching_squares_contour_cells_unit.sv]
// Top level of the marching squares contour cell unit.
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_stall  | sample
// out     | out | out_valid / out_stall| cell_row .. last_cell
// cfg     | in  | cfg_we               | cfg_idx, cfg_data
// The front takes one sample a cycle while in_stall is low; each cell with a contour
// runs through the one shared bit-serial divider in the back (29 bits each).
// Reset clears counters, neighbors, queue and control; the line store is not cleared.
// A full two-word queue stalls the front; out_stall holds the result register.
module marching_squares_contour_cells_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [15:0] sample,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] cell_row,
	output logic [7:0] cell_col,
	output logic [3:0] case_code,
	output logic [1:0] edge_a,
	output logic [12:0] frac_a,
	output logic [1:0] edge_b,
	output logic [12:0] frac_b,
	output logic last_cell,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [15:0] cfg_data
);
	import msq_pkg::*;

	logic signed [15:0] thr_q;
	logic [8:0] gw_q, gh_q;

	// Hold configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
			gw_q <= 9'd200;
			gh_q <= 9'd200;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_THRESHOLD: thr_q <= cfg_data;
				REG_WIDTH: gw_q <= cfg_data[8:0];
				REG_HEIGHT: gh_q <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	logic push, full, qv, pop;
	cell_t cin, cout;

	msq_front u_front (.clk, .arst_n, .in_valid, .in_stall, .sample, .thr(thr_q),
		.gw(gw_q), .gh(gh_q), .cell_valid(push), .cword(cin), .q_full(full));

	msq_queue u_queue (.clk, .arst_n, .push, .din(cin), .full, .pop_valid(qv), .pop,
		.dout(cout));

	msq_back u_back (.clk, .arst_n, .q_valid(qv), .q_pop(pop), .cword(cout), .out_valid,
		.out_stall, .cell_row, .cell_col, .case_code, .edge_a, .frac_a, .edge_b, .frac_b,
		.last_cell);
endmodule

[dv/msq_checker.sv]
// Checker for the contour cell unit: predicts each segment word and compares it.
module msq_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  logic signed [15:0] sample,
	input  logic out_valid,
	input  logic out_stall,
	input  logic [7:0] cell_row,
	input  logic [7:0] cell_col,
	input  logic [3:0] case_code,
	input  logic [1:0] edge_a,
	input  logic [12:0] frac_a,
	input  logic [1:0] edge_b,
	input  logic [12:0] frac_b,
	input  logic last_cell,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [15:0] cfg_data,
	output int fail_count,
	output int pending
);
	import msq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] CODE_NONE = 4'd0;
	localparam logic [3:0] CODE_ALL = 4'd15;
	localparam logic [3:0] SADDLE_A = 4'd5;
	localparam logic [3:0] SADDLE_B = 4'd10;
	localparam logic [1:0] E_TOP = 2'd0;
	localparam logic [1:0] E_RIGHT = 2'd1;
	localparam logic [1:0] E_BOTTOM = 2'd2;
	localparam logic [1:0] E_LEFT = 2'd3;
	localparam int ONE_Q = 1 << FracBits;

	typedef struct packed {
		logic [7:0] row;
		logic [7:0] col;
		logic [3:0] code;
		logic [1:0] ea;
		logic [12:0] fa;
		logic [1:0] eb;
		logic [12:0] fb;
		logic last;
	} segment_t;

	segment_t seg_q[$];

	// model state
	logic signed [15:0] line_mem [MaxWidth];
	logic signed [15:0] left_s, up_left_s;
	int col_pos, row_pos;
	logic signed [15:0] thr;
	logic [8:0] width_reg, height_reg;

	assign pending = seg_q.size();

	function automatic logic [12:0] cross_frac(int p, int q, int t);
		int num, den;
		longint r;
		begin
			num = t - p;
			den = q - p;
			if (den == 0 || num == 0) return 0;
			if ((num < 0) != (den < 0)) return 0;
			if (num < 0) num = -num;
			if (den < 0) den = -den;
			r = (longint'(num) << FracBits) / den;
			return (r > ONE_Q) ? 13'(ONE_Q) : 13'(r);
		end
	endfunction

	task automatic report(string what, int got, int want);
		begin
			$display("mismatch %s: got %0d want %0d", what, got, want);
			fail_count++;
		end
	endtask

	// advance the model by one sample, queue the segment if the cell is crossed
	task automatic predict_cell(logic signed [15:0] s);
		int w, h, c, r, t, sum, ne, k[4];
		logic [1:0] crossed[2], tmp;
		logic [3:0] code;
		logic signed [15:0] up;
		segment_t seg;
		begin
			w = (width_reg < 2) ? 2 : (width_reg > MaxWidth) ? MaxWidth : width_reg;
			h = (height_reg < 2) ? 2 : (height_reg > 256) ? 256 : height_reg;
			c = col_pos % MaxWidth;
			r = row_pos;
			t = thr;
			up = line_mem[c];
			if (r > 0 && c > 0) begin
				k[0] = up_left_s; k[1] = up; k[2] = s; k[3] = left_s;
				code = {k[3] < t, k[2] < t, k[1] < t, k[0] < t};
				if (code != CODE_NONE && code != CODE_ALL) begin
					sum = k[0] + k[1] + k[2] + k[3];
					if (code == SADDLE_A) begin
						crossed[0] = (sum > 4 * t) ? E_TOP : E_RIGHT;
						crossed[1] = (sum > 4 * t) ? E_LEFT : E_BOTTOM;
					end else if (code == SADDLE_B) begin
						crossed[0] = (sum <= 4 * t) ? E_TOP : E_RIGHT;
						crossed[1] = (sum <= 4 * t) ? E_LEFT : E_BOTTOM;
					end else begin
						ne = 0;
						for (int e = 0; e < 4; e++)
							if (code[e] != code[(e + 1) % 4]) begin
								crossed[ne] = 2'(e);
								ne++;
							end
						// left-right crossing is reported left edge first
						if (crossed[0] == E_RIGHT && crossed[1] == E_LEFT) begin
							tmp = crossed[0];
							crossed[0] = crossed[1];
							crossed[1] = tmp;
						end
					end
					seg.row = 8'(r - 1);
					seg.col = 8'(c - 1);
					seg.code = code;
					seg.ea = crossed[0];
					seg.fa = cross_frac(k[crossed[0]], k[(crossed[0] + 1) % 4], t);
					seg.eb = crossed[1];
					seg.fb = cross_frac(k[crossed[1]], k[(crossed[1] + 1) % 4], t);
					seg.last = (r == h - 1 && c == w - 1);
					seg_q = {seg_q, seg};
				end
			end
			up_left_s = up;
			left_s = s;
			line_mem[c] = s;
			c++;
			if (c >= w) begin
				c = 0;
				r++;
			end
			if (r >= h) r = 0;
			col_pos = c;
			row_pos = r;
		end
	endtask

	// watch config, input and output channels
	always @(posedge clk or negedge arst_n) begin
		segment_t want;
		if (!arst_n) begin
			left_s = 0;
			up_left_s = 0;
			col_pos = 0;
			row_pos = 0;
			thr = 0;
			width_reg = 200;
			height_reg = 200;
			seg_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (seg_q.size() == 0) begin
					report("unexpected segment word", 1, 0);
				end else begin
					want = seg_q.pop_front();
					if (cell_row != want.row) report("cell_row", cell_row, want.row);
					if (cell_col != want.col) report("cell_col", cell_col, want.col);
					if (case_code != want.code) report("case_code", case_code, want.code);
					if (edge_a != want.ea) report("edge_a", edge_a, want.ea);
					if (frac_a != want.fa) report("frac_a", frac_a, want.fa);
					if (edge_b != want.eb) report("edge_b", edge_b, want.eb);
					if (frac_b != want.fb) report("frac_b", frac_b, want.fb);
					if (last_cell != want.last) report("last_cell", last_cell, want.last);
				end
			end
			if (in_valid && !in_stall) predict_cell(sample);
			if (cfg_we) begin
				case (reg_idx_t'(cfg_idx))
					REG_THRESHOLD: thr = cfg_data;
					REG_WIDTH: width_reg = cfg_data[8:0];
					REG_HEIGHT: height_reg = cfg_data[8:0];
					default: ;
				endcase
			end
		end
	end

	initial fail_count = 0;
endmodule

[dv/tb_top.sv]
// Top of the contour cell testbench: stimulus, stalls, watchdog and verdict.
module tb_top;
	import msq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE = 200;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [15:0] sample = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [7:0] cell_row, cell_col;
	logic [3:0] case_code;
	logic [1:0] edge_a, edge_b;
	logic [12:0] frac_a, frac_b;
	logic last_cell;
	logic cfg_we = 0;
	logic [1:0] cfg_idx = REG_THRESHOLD;
	logic [15:0] cfg_data = 0;
	int fail_count, pending;
	bit burst = 0;
	int out_hold = 0;
	int idle_cycles = 0;
	logic signed [15:0] cur_thr = 0;

	always #10 clk = ~clk;

	marching_squares_contour_cells_unit dut (.*);
	msq_checker chk (.*);

	// draw a stall length after each taken word
	always @(posedge clk) begin
		int n;
		if (out_hold > 0) begin
			out_hold <= out_hold - 1;
			out_stall <= 1;
		end else if (out_valid && !out_stall) begin
			n = burst ? 0 : $urandom_range(0, 9);
			out_stall <= (n > 0);
			out_hold <= (n > 0) ? n - 1 : 0;
		end else begin
			out_stall <= 0;
		end
	end

	// end the run if no word moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// send one sample word after a random gap, or with no gap in burst mode
	task automatic push_sample(logic signed [15:0] v);
		int gap;
		bit st;
		begin
			gap = burst ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1;
			sample <= v;
			do begin
				@(negedge clk);
				st = in_stall;
				@(posedge clk);
			end while (st);
		end
	endtask

	// drain, let the back end settle, then write a register
	task automatic write_reg(reg_idx_t idx, logic [15:0] v);
		begin
			in_valid <= 0;
			@(posedge clk);
			while (pending != 0) @(posedge clk);
			repeat (SETTLE) @(posedge clk);
			cfg_we <= 1;
			cfg_idx <= idx;
			cfg_data <= v;
			@(posedge clk);
			cfg_we <= 0;
			if (idx == REG_THRESHOLD) cur_thr = v;
		end
	endtask

	function automatic logic signed [15:0] pick_sample();
		int m, v;
		begin
			m = $urandom_range(0, 7);
			if (m < 4) begin
				v = cur_thr + $signed($urandom_range(0, 600)) - 300;
				if (v > 32767) v = 32767;
				if (v < -32768) v = -32768;
				return 16'(v);
			end
			if (m < 6) return 16'($urandom);
			case ($urandom_range(0, 3))
				0: return -16'sd32768;
				1: return 16'sd32767;
				2: return cur_thr;
				default: return cur_thr - 16'sd1;
			endcase
		end
	endfunction

	int widths[8] = '{0, 1, 3, 5, 16, 300, 511, 7};
	int heights[8] = '{1, 2, 511, 4, 3, 2, 3, 9};
	logic signed [15:0] directed[24] = '{
		16'sd100, -16'sd100, 16'sd0, -16'sd32768, 16'sd32767, -16'sd1,
		-16'sd50, 16'sd50, 16'sd200, 16'sd10, 16'sd10, -16'sd10,
		16'sd60, -16'sd90, -16'sd90, -16'sd32768, -16'sd32768, 16'sd32767,
		16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd0, 16'sd0};

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// fill every line store entry with one full-width row first
		write_reg(REG_WIDTH, 16'd256);
		write_reg(REG_HEIGHT, 16'd256);
		burst = 1;
		for (int i = 0; i < 256; i++) push_sample(pick_sample());
		burst = 0;
		// directed: small grid, extremes, saddles and equal corners
		write_reg(REG_WIDTH, 16'd3);
		write_reg(REG_HEIGHT, 16'd3);
		foreach (directed[i]) push_sample(directed[i]);
		// random phases over many sizes and thresholds
		for (int p = 0; p < 10; p++) begin
			case (p)
				0: write_reg(REG_THRESHOLD, 16'h8000);
				1: write_reg(REG_THRESHOLD, 16'h7fff);
				default: write_reg(REG_THRESHOLD, 16'($urandom_range(0, 4000)) - 16'd2000);
			endcase
			write_reg(REG_WIDTH, 16'(widths[p % 8]));
			write_reg(REG_HEIGHT, 16'(heights[p % 8]));
			burst = (p % 3 == 2);
			for (int i = 0; i < ((p < 2) ? 20 : 60); i++) push_sample(pick_sample());
		end
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/msq_pkg.sv
hw/rtl/msq_front.sv
hw/rtl/msq_queue.sv
hw/rtl/msq_back.sv
hw/rtl/marching_squares_contour_cells_unit.sv
dv/msq_checker.sv
dv/tb_top.sv
